/* hdl/rsi_pkg.sv */
// Shared types and constants for the relative strength index core.
// Depends on nothing; every other file of the block imports it.
package rsi_pkg;

  // Fixed field widths of the item and result words.
  localparam int PRICE_W  = 32;
  localparam int RSI_W    = 23;
  localparam int PERIOD_W = 8;
  localparam int COUNT_W  = 9;

  // Width of the running sums and averages.
  localparam int ACC_W = 64;

  // The RSI scale factor of one hundred and its width.
  localparam int SCALE_W = 7;
  localparam logic [SCALE_W-1:0] SCALE = 7'd100;

  // The period divider retires this many quotient bits per cycle.
  localparam int PDIV_RADIX_BITS = 4;
  localparam int PDIV_STEPS      = ACC_W / PDIV_RADIX_BITS;

  // Configuration register map.
  localparam int APB_ADDR_W = 1;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] ADDR_PERIOD  = 1'b0;
  localparam logic [PERIOD_W-1:0]   PERIOD_RESET = 8'd14;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture a word and update the running state
    logic prep;       // form the two dividends of the period division
    logic pdiv_step;  // one radix-16 step of both period divisions
    logic setup;      // store averages and set up the RSI division
    logic rdiv_step;  // one bit of the RSI division
    logic out_load;   // load the result register
  } rsi_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;   // the current word produces a defined RSI
  } rsi_sts_t;

endpackage

/* hdl/rsi_if.sv */
// Valid/ready channel interfaces for the input words and the result words.
// Depends on rsi_pkg for the field widths.
interface rsi_in_if import rsi_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PRICE_W-1:0] price;
  logic               series_start;

  modport source (output valid, output price, output series_start, input ready);
  modport sink   (input valid, input price, input series_start, output ready);
endinterface

interface rsi_out_if import rsi_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RSI_W-1:0] rsi;
  logic             valid_res;

  modport source (output valid, output rsi, output valid_res, input ready);
  modport sink   (input valid, input rsi, input valid_res, output ready);
endinterface

/* hdl/rsi_datapath.sv */
// Datapath of the RSI core: running state, period dividers, RSI divider and
// the result register. Depends on rsi_pkg; driven by rsi_ctrl commands.
module rsi_datapath import rsi_pkg::*; #(
  parameter int FRAC_BITS  = 16,
  parameter int PRICE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rsi_cmd_t            cmd,
  output rsi_sts_t            sts,
  input  logic [PRICE_W-1:0]  in_price,
  input  logic                in_series_start,
  input  logic [PERIOD_W-1:0] period,
  output logic [RSI_W-1:0]    rsi,
  output logic                valid_res
);

  // Width of the RSI dividend: gain times one hundred, shifted by the fraction.
  localparam int DW = ACC_W + SCALE_W + FRAC_BITS;

  typedef struct packed {
    logic [ACC_W-1:0]    num;
    logic [PERIOD_W-1:0] rem;
  } pdiv_t;

  // Four restoring steps of a division by the period. Quotient bits enter
  // the dividend register from the bottom as its top bits leave.
  function automatic pdiv_t pdiv4(input pdiv_t cur, input logic [PERIOD_W-1:0] d);
    pdiv_t             res;
    logic [PERIOD_W:0] r9;
    res = cur;
    for (int k = 0; k < PDIV_RADIX_BITS; k++) begin
      r9      = {res.rem, res.num[ACC_W-1]};
      res.num = {res.num[ACC_W-2:0], 1'b0};
      if (r9 >= {1'b0, d}) begin
        r9         = r9 - {1'b0, d};
        res.num[0] = 1'b1;
      end
      res.rem = r9[PERIOD_W-1:0];
    end
    return res;
  endfunction

  // Architectural state.
  logic [PRICE_BITS-1:0] last_price_r;
  logic [COUNT_W-1:0]    count_r;
  logic [ACC_W-1:0]      gain_r, loss_r;
  logic                  need_div_r;

  // Working registers.
  logic [ACC_W-1:0]    prod_g_r, prod_l_r, add_g_r, add_l_r;
  logic [ACC_W-1:0]    num_g_r, num_l_r;
  logic [PERIOD_W-1:0] rem_g_r, rem_l_r;
  logic [DW-1:0]       rnum_r;
  logic [ACC_W-1:0]    rrem_r, rden_r;
  logic                rzero_r;
  logic [RSI_W-1:0]    rsi_r;
  logic                valid_res_r;

  // Difference split into gain and loss; a zero difference is a zero loss.
  logic [PRICE_BITS-1:0] price_m, delta;
  logic                  is_gain;
  logic [ACC_W-1:0]      g64, l64, sum_g, sum_l;
  logic [PERIOD_W-1:0]   pe, pm1;
  logic                  warm;
  logic [COUNT_W-1:0]    count_nxt;
  logic [ACC_W+PERIOD_W-1:0] mul_g, mul_l;

  assign price_m = in_price[PRICE_BITS-1:0];
  assign is_gain = price_m > last_price_r;
  assign delta   = is_gain ? (price_m - last_price_r) : (last_price_r - price_m);
  assign g64     = is_gain ? ACC_W'(delta) : '0;
  assign l64     = is_gain ? '0 : ACC_W'(delta);
  assign sum_g   = gain_r + g64;
  assign sum_l   = loss_r + l64;

  // A period of zero behaves as a period of one.
  assign pe   = (period == '0) ? PERIOD_W'(1) : period;
  assign pm1  = pe - PERIOD_W'(1);
  assign warm = count_r < {1'b0, pe};

  assign count_nxt = (count_r == '1) ? count_r : count_r + COUNT_W'(1);
  assign mul_g     = gain_r * pm1;
  assign mul_l     = loss_r * pm1;

  // Period division step for both averages.
  pdiv_t pd_g_nxt, pd_l_nxt;
  assign pd_g_nxt = pdiv4('{num: num_g_r, rem: rem_g_r}, pe);
  assign pd_l_nxt = pdiv4('{num: num_l_r, rem: rem_l_r}, pe);

  // RSI division setup and one restoring step.
  logic [ACC_W+SCALE_W-1:0] scaled;
  logic [ACC_W-1:0]         total;
  logic [ACC_W:0]           r_try, r_diff;
  logic                     r_fits;
  logic [ACC_W-1:0]         rrem_nxt;

  assign scaled   = num_g_r * SCALE;
  assign total    = num_g_r + num_l_r;
  assign r_try    = {rrem_r, rnum_r[DW-1]};
  assign r_diff   = r_try - {1'b0, rden_r};
  assign r_fits   = r_try >= {1'b0, rden_r};
  assign rrem_nxt = r_fits ? r_diff[ACC_W-1:0] : r_try[ACC_W-1:0];

  // Running state, cleared by reset and by the start of a series.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_price_r <= '0;
      count_r      <= '0;
      gain_r       <= '0;
      loss_r       <= '0;
      need_div_r   <= 1'b0;
    end else if (cmd.load) begin
      last_price_r <= price_m;
      if (in_series_start) begin
        count_r    <= '0;
        gain_r     <= '0;
        loss_r     <= '0;
        need_div_r <= 1'b0;
      end else if (warm) begin
        gain_r     <= sum_g;
        loss_r     <= sum_l;
        count_r    <= count_r + COUNT_W'(1);
        need_div_r <= (count_r + COUNT_W'(1)) == {1'b0, pe};
      end else begin
        count_r    <= count_nxt;
        need_div_r <= 1'b1;
      end
    end else if (cmd.setup) begin
      gain_r <= num_g_r;
      loss_r <= num_l_r;
    end
  end

  // Terms of the period division: a scaled sum at the end of warm-up, or
  // the weighted old average plus the scaled new difference afterwards.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (warm) begin
        prod_g_r <= sum_g << FRAC_BITS;
        prod_l_r <= sum_l << FRAC_BITS;
        add_g_r  <= '0;
        add_l_r  <= '0;
      end else begin
        prod_g_r <= mul_g[ACC_W-1:0];
        prod_l_r <= mul_l[ACC_W-1:0];
        add_g_r  <= g64 << FRAC_BITS;
        add_l_r  <= l64 << FRAC_BITS;
      end
    end
  end

  // Period dividers for the gain and loss averages.
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      num_g_r <= prod_g_r + add_g_r;
      num_l_r <= prod_l_r + add_l_r;
      rem_g_r <= '0;
      rem_l_r <= '0;
    end else if (cmd.pdiv_step) begin
      num_g_r <= pd_g_nxt.num;
      num_l_r <= pd_l_nxt.num;
      rem_g_r <= pd_g_nxt.rem;
      rem_l_r <= pd_l_nxt.rem;
    end
  end

  // RSI divider: gain times 100 scaled, over the sum of the averages.
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      rnum_r  <= {scaled, {FRAC_BITS{1'b0}}};
      rden_r  <= total;
      rzero_r <= total == '0;
      rrem_r  <= '0;
    end else if (cmd.rdiv_step) begin
      rnum_r <= {rnum_r[DW-2:0], r_fits};
      rrem_r <= rrem_nxt;
    end
  end

  // Result register; the quotient is kept modulo the field width.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      valid_res_r <= need_div_r;
      rsi_r       <= (need_div_r && !rzero_r) ? rnum_r[RSI_W-1:0] : '0;
    end
  end

  assign sts.need_div = need_div_r;
  assign rsi          = rsi_r;
  assign valid_res    = valid_res_r;

endmodule

/* hdl/rsi_ctrl.sv */
// Controller of the RSI core: sequences the datapath through the period
// divisions and the RSI division. Depends on rsi_pkg.
module rsi_ctrl import rsi_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  rsi_sts_t sts,
  output rsi_cmd_t cmd
);

  localparam int RDIV_STEPS = ACC_W + SCALE_W + FRAC_BITS;
  localparam int CNT_W      = $clog2(RDIV_STEPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_PDIV,
    ST_SETUP,
    ST_RDIV,
    ST_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             in_fire, out_free;

  assign in_ready = state_r == ST_IDLE;
  assign in_fire  = in_ready && in_valid;
  assign out_free = !out_valid_r || out_ready;

  // Command decode.
  always_comb begin
    cmd           = '0;
    cmd.load      = in_fire;
    cmd.prep      = state_r == ST_PREP;
    cmd.pdiv_step = state_r == ST_PDIV;
    cmd.setup     = state_r == ST_SETUP;
    cmd.rdiv_step = state_r == ST_RDIV;
    cmd.out_load  = (state_r == ST_DONE) && out_free;
  end

  // Next state, step counter and output valid.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cnt_nxt   = '0;
        state_nxt = sts.need_div ? ST_PDIV : ST_DONE;
      end
      ST_PDIV: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(PDIV_STEPS - 1)) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cnt_nxt   = '0;
        state_nxt = ST_RDIV;
      end
      ST_RDIV: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(RDIV_STEPS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* hdl/relative_strength_index_core.sv */
// Top level of the Wilder RSI core: APB period register, controller and
// datapath. Depends on rsi_pkg, rsi_if, rsi_ctrl and rsi_datapath.
//
// Usage. Price words arrive on in_ch (valid/ready); a word with
// series_start set begins a new series and clears the running state.
// Every accepted word produces exactly one result word on out_ch, carrying
// the RSI in unsigned fixed point with FRAC_BITS fraction bits and a
// valid_res flag that is set once the averaging window is filled.
// The period register sits at APB address 0 and must be written only while
// the core is idle; the core itself does not enforce this. A period of
// zero acts as a period of one. A word that yields no defined RSI passes
// from accept through the prep step to the result register. A word that
// yields an RSI passes through the prep step, the radix-16 dividers by
// the period, the setup step and the bit-serial RSI divider, which makes
// one quotient bit per cycle, and then loads the result register.
// One word is processed at a time, and the next word is taken the cycle
// after the result register loads. A finished result waits in the output
// register; the next word is taken while it waits, and the core holds in
// its last step until it is taken.
// Reset (synchronous, active low) clears the state and sets the period
// to 14.
module relative_strength_index_core import rsi_pkg::*; #(
  parameter int FRAC_BITS  = 16,
  parameter int PRICE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rsi_in_if.sink                in_ch,
  rsi_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  rsi_cmd_t            cmd;
  rsi_sts_t            sts;
  logic [PERIOD_W-1:0] period_r;

  // Period register on the APB port; no wait states.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_PERIOD) begin
      period_r <= pwdata[PERIOD_W-1:0];
    end
  end

  assign prdata = (paddr == ADDR_PERIOD) ? APB_DATA_W'(period_r) : '0;

  rsi_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rsi_datapath #(
    .FRAC_BITS  (FRAC_BITS),
    .PRICE_BITS (PRICE_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_price        (in_ch.price),
    .in_series_start (in_ch.series_start),
    .period          (period_r),
    .rsi             (out_ch.rsi),
    .valid_res       (out_ch.valid_res)
  );

endmodule
